// ----- src/sbf_pkg.sv -----
// Package with shared types, register indexes and fold helpers for the box fold transform.
package sbf_pkg;

  localparam int unsigned NumRegs = 8;
  localparam logic [2:0] RegXLo = 3'd0;
  localparam logic [2:0] RegXHi = 3'd1;
  localparam logic [2:0] RegYLo = 3'd2;
  localparam logic [2:0] RegYHi = 3'd3;
  localparam logic [2:0] RegZLo = 3'd4;
  localparam logic [2:0] RegZHi = 3'd5;
  localparam logic [2:0] RegWeights = 3'd6;
  localparam logic [2:0] RegControl = 3'd7;

  localparam logic signed [31:0] S32Max = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32Min = 32'sh8000_0000;

  typedef logic signed [15:0] q412_t;
  typedef logic signed [31:0] coord_t;

  // Per-axis fold constants, all in Q8.24, and the fold enables.
  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] f;
    logic signed [31:0] o;
    logic signed [31:0] lim;
    logic signed [31:0] val;
    logic signed [31:0] s;
    logic signed [31:0] h;
    logic [4:0]         en;
  } axis_cfg_t;

  function automatic logic signed [35:0] abs36(input logic signed [35:0] v);
    abs36 = v[35] ? -v : v;
  endfunction

  function automatic coord_t sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) sat32 = S32Max;
    else if (v < -36'sd2147483648) sat32 = S32Min;
    else sat32 = v[31:0];
  endfunction

  function automatic coord_t fold_clamp(input coord_t z, input logic signed [31:0] a);
    logic signed [35:0] zz, aa;
    zz = 36'(z);
    aa = 36'(a);
    fold_clamp = sat32(abs36(zz + aa) - abs36(zz - aa) - zz);
  endfunction

  function automatic coord_t fold_box(input coord_t z, input logic signed [31:0] f);
    logic signed [35:0] zz, ff;
    zz = 36'(z);
    ff = 36'(f);
    fold_box = sat32(ff - abs36(abs36(zz) - ff));
  endfunction

  function automatic coord_t fold_abs(input coord_t z, input logic signed [31:0] o);
    fold_abs = sat32(abs36(36'(z) + 36'(o)));
  endfunction

  function automatic coord_t fold_reflect(input coord_t z, input logic signed [31:0] lim,
                                          input logic signed [31:0] val);
    logic signed [35:0] zz, ll, vv;
    zz = 36'(z);
    ll = 36'(lim);
    vv = 36'(val);
    if (zz > ll) fold_reflect = sat32(vv - zz);
    else if (zz < -ll) fold_reflect = sat32(-vv - zz);
    else fold_reflect = z;
  endfunction

  function automatic coord_t fold_double(input coord_t z, input logic signed [31:0] s,
                                         input logic signed [31:0] h);
    logic signed [35:0] zz, ss, hh;
    zz = 36'(z);
    ss = 36'(s);
    hh = 36'(h);
    fold_double = sat32(ss - abs36(abs36(zz + hh) - ss) - hh);
  endfunction

endpackage

// ----- src/surface_box_fold_transform.sv -----
// Top level of the per-axis box fold transform with distance and color update.
// Usage: pulse start with a point, distance, color and iteration; busy is
// always low, so a word is taken on every cycle that start is high.
// Configuration goes through cfg_we_i / cfg_idx_i / cfg_data_i while no word
// is in flight; every 3-bit index names one of the eight registers.
// Pipeline: stage 1 clamp and box folds, stage 2 abs and reflect folds,
// stage 3 double fold and the distance multiply, stage 4 color weight
// products and distance round, stage 5 color sum, round and saturation. A
// result appears on the output ports after stage 5, with done_o high for
// exactly one cycle. Throughput is one word per cycle.
// Reset clears the configuration registers and the valid bits, which empties
// the pipeline. The receiver cannot stall, so no backpressure exists.
module surface_box_fold_transform (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               done_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic signed [31:0] dist_in_i,
  input  logic [31:0]        color_in_i,
  input  logic [7:0]         iteration_i,
  output logic signed [31:0] folded_x_o,
  output logic signed [31:0] folded_y_o,
  output logic signed [31:0] folded_z_o,
  output logic signed [31:0] dist_out_o,
  output logic [31:0]        color_out_o
);

  logic [63:0] regs_q [sbf_pkg::NumRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sbf_pkg::NumRegs; i++) regs_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sbf_pkg::RegWeights: regs_q[cfg_idx_i] <= {16'd0, cfg_data_i[47:0]};
        sbf_pkg::RegControl: regs_q[cfg_idx_i] <= {32'd0, cfg_data_i[31:0]};
        default:             regs_q[cfg_idx_i] <= cfg_data_i;
      endcase
    end
  end

  function automatic sbf_pkg::q412_t fld(input logic [63:0] r, input int k);
    fld = r[16*k +: 16];
  endfunction

  function automatic logic signed [31:0] wide(input sbf_pkg::q412_t v);
    wide = {{4{v[15]}}, v, 12'd0};
  endfunction

  logic [31:0] ctl;
  sbf_pkg::axis_cfg_t cfg [3];
  logic signed [31:0] z_lim, z_val;

  assign ctl   = regs_q[sbf_pkg::RegControl][31:0];
  assign z_lim = 32'(fld(regs_q[sbf_pkg::RegZLo], 3) * fld(regs_q[sbf_pkg::RegZHi], 3));
  assign z_val = 32'(fld(regs_q[sbf_pkg::RegZHi], 0) * fld(regs_q[sbf_pkg::RegZHi], 3));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cfg[i].a   = wide(fld(regs_q[2*i], 0));
      cfg[i].f   = wide(fld(regs_q[2*i], 1));
      cfg[i].o   = wide(fld(regs_q[2*i], 2));
      cfg[i].lim = wide(fld(regs_q[2*i], 3));
      cfg[i].val = wide(fld(regs_q[2*i+1], 0));
      cfg[i].s   = wide(fld(regs_q[2*i+1], 1));
      cfg[i].h   = wide(fld(regs_q[2*i+1], 2));
      cfg[i].en  = ctl[5*i +: 5];
    end
    cfg[2].lim = z_lim;
    cfg[2].val = z_val;
  end

  logic col_on;
  assign col_on = ctl[15] && (iteration_i >= ctl[23:16]) && (iteration_i < ctl[31:24]);

  // Valid bits.
  logic [4:0] v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else v_q <= {v_q[3:0], start};
  end
  assign busy = 1'b0;
  assign done_o = v_q[4];

  sbf_pkg::coord_t old1_q [3], z1_q [3], old2_q [3], z2_q [3], old3_q [3], z3_q [3];
  sbf_pkg::coord_t z4_q [3], z5_q [3];
  logic signed [31:0] d1_q, d2_q;
  logic signed [47:0] dp3_q;
  logic signed [31:0] d4_q, d5_q;
  logic [31:0] c1_q, c2_q, c3_q, c4_q, c5_q;
  logic on1_q, on2_q, on3_q, on4_q;
  logic signed [48:0] wp4_q [3];

  always_ff @(posedge clk_i) begin
    // Stage 1: clamp and box folds.
    for (int i = 0; i < 3; i++) begin
      sbf_pkg::coord_t t;
      t = (i == 0) ? point_x_i : (i == 1) ? point_y_i : point_z_i;
      old1_q[i] <= t;
      if (cfg[i].en[0]) t = sbf_pkg::fold_clamp(t, cfg[i].a);
      if (cfg[i].en[1]) t = sbf_pkg::fold_box(t, cfg[i].f);
      z1_q[i] <= t;
    end
    d1_q <= dist_in_i;
    c1_q <= color_in_i;
    on1_q <= col_on;
    // Stage 2: abs and reflect folds.
    for (int i = 0; i < 3; i++) begin
      sbf_pkg::coord_t t;
      t = z1_q[i];
      if (cfg[i].en[2]) t = sbf_pkg::fold_abs(t, cfg[i].o);
      if (cfg[i].en[3]) t = sbf_pkg::fold_reflect(t, cfg[i].lim, cfg[i].val);
      z2_q[i] <= t;
      old2_q[i] <= old1_q[i];
    end
    d2_q <= d1_q;
    c2_q <= c1_q;
    on2_q <= on1_q;
    // Stage 3: double fold, distance product.
    for (int i = 0; i < 3; i++) begin
      z3_q[i] <= cfg[i].en[4] ? sbf_pkg::fold_double(z2_q[i], cfg[i].s, cfg[i].h) : z2_q[i];
      old3_q[i] <= old2_q[i];
    end
    dp3_q <= 48'(d2_q * fld(regs_q[sbf_pkg::RegXHi], 3));
    c3_q <= c2_q;
    on3_q <= on2_q;
    // Stage 4: color weight products and distance round.
    for (int i = 0; i < 3; i++) begin
      logic signed [33:0] df;
      df = 34'(z3_q[i]) - 34'(old3_q[i]);
      if (df[33]) df = -df;
      wp4_q[i] <= 49'(df * fld(regs_q[sbf_pkg::RegWeights], i));
      z4_q[i] <= z3_q[i];
    end
    begin
      logic signed [48:0] r;
      r = ((49'(dp3_q) + 49'sd2048) >>> 12) + 49'(fld(regs_q[sbf_pkg::RegYHi], 3)) * 49'sd16;
      if (r > 49'sd2147483647) d4_q <= sbf_pkg::S32Max;
      else if (r < -49'sd2147483648) d4_q <= sbf_pkg::S32Min;
      else d4_q <= r[31:0];
    end
    c4_q <= c3_q;
    on4_q <= on3_q;
    // Stage 5: color sum and saturation.
    begin
      logic signed [51:0] sm, cc;
      sm = 52'(wp4_q[0]) + 52'(wp4_q[1]) + 52'(wp4_q[2]);
      cc = 52'($signed({1'b0, c4_q})) + ((sm + 52'sd524288) >>> 20);
      if (!on4_q) c5_q <= c4_q;
      else if (cc < 0) c5_q <= '0;
      else if (cc > 52'sd4294967295) c5_q <= 32'hFFFF_FFFF;
      else c5_q <= cc[31:0];
    end
    for (int i = 0; i < 3; i++) z5_q[i] <= z4_q[i];
    d5_q <= d4_q;
  end

  assign folded_x_o  = z5_q[0];
  assign folded_y_o  = z5_q[1];
  assign folded_z_o  = z5_q[2];
  assign dist_out_o  = d5_q;
  assign color_out_o = c5_q;

`ifndef SYNTH
  a_done_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##5 done_o) else $error("result strobe missing");
  a_no_spur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 5)) else $error("spurious result strobe");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy) else $error("busy raised");
`endif

endmodule
